>>> rtl/fbd_pkg.sv
// shared types, constants and tables for the fractional baud divisor
package fbd_pkg;

    // field and register widths
    localparam int RATE_BITS = 24;
    localparam int BAUD_W    = 24;
    localparam int BASE_W    = 24;
    localparam int LIM_W     = 18;
    localparam int CODE_W    = 16;
    localparam int INT_W     = 14;
    localparam int FRAC_W    = 2;

    // divider geometry: dividend is base clock times sixteen
    localparam int DIV_W      = BASE_W + 4;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;
    localparam int RND_W      = DIV_W + 1;

    // tolerance arithmetic widths
    localparam int PROD_W = RATE_BITS + LIM_W;
    localparam int SCL_W  = PROD_W + 7;
    localparam int ATH_W  = DIV_W + 7;

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_MAX    = 2'd2;

    // config reset values
    localparam logic [BASE_W-1:0] BASE_CLOCK_RST = BASE_W'(3000000);
    localparam logic [LIM_W-1:0]  DIV_MIN_RST    = LIM_W'(32);
    localparam logic [LIM_W-1:0]  DIV_MAX_RST    = LIM_W'(262136);

    // windows around the dedicated rates
    localparam logic [RATE_BITS-1:0] NEAR3M_LO = RATE_BITS'(3000000 * 100 / 103);
    localparam logic [RATE_BITS-1:0] NEAR3M_HI = RATE_BITS'(3000000 * 100 / 97);
    localparam logic [RATE_BITS-1:0] NEAR2M_LO = RATE_BITS'(2000000 * 100 / 103);
    localparam logic [RATE_BITS-1:0] NEAR2M_HI = RATE_BITS'(2000000 * 100 / 97);

    // request kinds
    localparam logic [1:0] KIND_CALC   = 2'd0;
    localparam logic [1:0] KIND_ZERO   = 2'd1;
    localparam logic [1:0] KIND_NEAR3M = 2'd2;
    localparam logic [1:0] KIND_NEAR2M = 2'd3;

    // fixed codes for the dedicated rates
    localparam logic [CODE_W-1:0] CODE_3M = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_2M = CODE_W'(1);

    // fraction field codes
    localparam logic [FRAC_W-1:0] FRAC_NONE    = 2'd0;
    localparam logic [FRAC_W-1:0] FRAC_HALF    = 2'd1;
    localparam logic [FRAC_W-1:0] FRAC_QUARTER = 2'd2;
    localparam logic [FRAC_W-1:0] FRAC_EIGHTH  = 2'd3;

    // tolerance scale
    localparam logic [SCL_W-1:0] TOL_HI_ADD = SCL_W'(103);

    // what travels alongside each beat
    typedef struct packed {
        logic [1:0]           kind;
        logic [RATE_BITS-1:0] rate;
    } fbd_side_t;

    // power-of-two rounding of the low four divisor bits
    function automatic logic [4:0] round_lsb(input logic [3:0] lsb);
        logic [4:0] r;
        case (lsb)
            4'd0:                      r = 5'd0;
            4'd1, 4'd2:                r = 5'd2;
            4'd3, 4'd4, 4'd5:          r = 5'd4;
            4'd6, 4'd7, 4'd8, 4'd9,
            4'd10, 4'd11:              r = 5'd8;
            default:                   r = 5'd16;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/fbd_div.sv
// pipelined restoring divider, two quotient bits per stage
module fbd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  fbd_pkg::fbd_side_t           in_side,
    input  logic [fbd_pkg::DIV_W-1:0]    in_dividend,
    output logic                         out_valid,
    input  logic                         out_ready,
    output fbd_pkg::fbd_side_t           out_side,
    output logic [fbd_pkg::DIV_W-1:0]    out_quot
);

    localparam int NS = fbd_pkg::DIV_STAGES;
    localparam int RW = fbd_pkg::RATE_BITS;
    localparam int DW = fbd_pkg::DIV_W;

    logic                 vld_reg  [NS];
    logic [RW-1:0]        rem_reg  [NS];
    logic [DW-1:0]        num_reg  [NS];
    fbd_pkg::fbd_side_t   side_reg [NS];

    logic                 stg_vld  [NS];
    logic [RW-1:0]        stg_rem  [NS];
    logic [DW-1:0]        stg_num  [NS];
    fbd_pkg::fbd_side_t   stg_side [NS];

    logic [RW-1:0]        rem_next [NS];
    logic [DW-1:0]        num_next [NS];

    logic [NS:0]          en;

    assign en[NS]   = out_ready;
    assign in_ready = en[0];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        // stage advance: empty or downstream moving
        assign en[k] = ~vld_reg[k] | en[k+1];

        // stage input select
        if (k == 0) begin : g_first
            assign stg_vld[k]  = in_valid;
            assign stg_rem[k]  = '0;
            assign stg_num[k]  = in_dividend;
            assign stg_side[k] = in_side;
        end else begin : g_next
            assign stg_vld[k]  = vld_reg[k-1];
            assign stg_rem[k]  = rem_reg[k-1];
            assign stg_num[k]  = num_reg[k-1];
            assign stg_side[k] = side_reg[k-1];
        end

        // shift-subtract steps, quotient bits shift in at the bottom
        always_comb begin : div_step
            logic [RW:0]   trial;
            logic [RW-1:0] r;
            logic [DW-1:0] n;
            r = stg_rem[k];
            n = stg_num[k];
            for (int j = 0; j < fbd_pkg::DIV_STEP; j++) begin
                trial = {r, n[DW-1]} - {1'b0, stg_side[k].rate};
                if (!trial[RW]) begin
                    r = trial[RW-1:0];
                end else begin
                    r = {r[RW-2:0], n[DW-1]};
                end
                n = {n[DW-2:0], ~trial[RW]};
            end
            rem_next[k] = r;
            num_next[k] = n;
        end

        // valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en[k]) begin
                vld_reg[k] <= stg_vld[k];
            end
        end

        // payload
        always_ff @(posedge aclk) begin
            if (en[k] && stg_vld[k]) begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= num_next[k];
                side_reg[k] <= stg_side[k];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_quot  = num_reg[NS-1];

endmodule

>>> rtl/fbd_rnd.sv
// rounding of the low divisor bits and clamp to the configured limits
module fbd_rnd (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  fbd_pkg::fbd_side_t           in_side,
    input  logic [fbd_pkg::DIV_W-1:0]    in_quot,
    input  logic [fbd_pkg::LIM_W-1:0]    divisor_min,
    input  logic [fbd_pkg::LIM_W-1:0]    divisor_max,
    output logic                         out_valid,
    input  logic                         out_ready,
    output fbd_pkg::fbd_side_t           out_side,
    output logic [fbd_pkg::LIM_W-1:0]    out_div
);

    localparam int RW = fbd_pkg::RND_W;
    localparam int DW = fbd_pkg::DIV_W;
    localparam int LW = fbd_pkg::LIM_W;

    logic               vld_reg;
    fbd_pkg::fbd_side_t side_reg;
    logic [LW-1:0]      div_reg;

    logic [RW-1:0]      rounded;
    logic [LW-1:0]      div_next;
    logic               en;

    assign en       = ~vld_reg | out_ready;
    assign in_ready = en;

    // round the sixteenths, carry goes into the integer part
    assign rounded = {1'b0, in_quot[DW-1:4], 4'b0000}
                   + RW'(fbd_pkg::round_lsb(in_quot[3:0]));

    // floor first, then ceiling
    always_comb begin
        if (rounded < RW'(divisor_min)) begin
            div_next = divisor_min;
        end else if (rounded > RW'(divisor_max)) begin
            div_next = divisor_max;
        end else begin
            div_next = rounded[LW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

endmodule

>>> rtl/fbd_tol.sv
// rate times divisor, tolerance window check and code packing
module fbd_tol (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbd_pkg::fbd_side_t            in_side,
    input  logic [fbd_pkg::LIM_W-1:0]     in_div,
    input  logic [fbd_pkg::ATH_W-1:0]     tol_ref,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_rate_ok,
    output logic [fbd_pkg::CODE_W-1:0]    out_code
);

    localparam int PW = fbd_pkg::PROD_W;
    localparam int SW = fbd_pkg::SCL_W;
    localparam int LW = fbd_pkg::LIM_W;
    localparam int CW = fbd_pkg::CODE_W;

    // product stage
    logic          mul_vld_reg;
    logic [1:0]    mul_kind_reg;
    logic [LW-1:0] mul_div_reg;
    logic [PW-1:0] mul_prod_reg;

    // scale stage
    logic          scl_vld_reg;
    logic [1:0]    scl_kind_reg;
    logic [LW-1:0] scl_div_reg;
    logic [SW-1:0] scl_p97_reg;
    logic [SW-1:0] scl_p6_reg;

    // output stage
    logic          out_vld_reg;
    logic          ok_reg;
    logic [CW-1:0] code_reg;

    logic          en_mul;
    logic          en_scl;
    logic          en_out;
    logic [SW-1:0] prod_ext;
    logic [SW-1:0] p103;
    logic [SW-1:0] ref_ext;
    logic          in_window;
    logic [fbd_pkg::FRAC_W-1:0] frac;
    logic          ok_next;
    logic [CW-1:0] code_next;

    assign en_out   = ~out_vld_reg | out_ready;
    assign en_scl   = ~scl_vld_reg | en_out;
    assign en_mul   = ~mul_vld_reg | en_scl;
    assign in_ready = en_mul;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            scl_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (en_mul) begin
                mul_vld_reg <= in_valid;
            end
            if (en_scl) begin
                scl_vld_reg <= mul_vld_reg;
            end
            if (en_out) begin
                out_vld_reg <= scl_vld_reg;
            end
        end
    end

    // rate times divisor
    always_ff @(posedge aclk) begin
        if (en_mul && in_valid) begin
            mul_kind_reg <= in_side.kind;
            mul_div_reg  <= in_div;
            mul_prod_reg <= PW'(in_side.rate) * PW'(in_div);
        end
    end

    // times 97, and times 6 plus 103 for the low bound
    assign prod_ext = SW'(mul_prod_reg);

    always_ff @(posedge aclk) begin
        if (en_scl && mul_vld_reg) begin
            scl_kind_reg <= mul_kind_reg;
            scl_div_reg  <= mul_div_reg;
            scl_p97_reg  <= (prod_ext << 6) + (prod_ext << 5) + prod_ext;
            scl_p6_reg   <= (prod_ext << 2) + (prod_ext << 1) + fbd_pkg::TOL_HI_ADD;
        end
    end

    // window: 103 * (prod + 1) > ref and 97 * prod <= ref
    assign ref_ext   = SW'(tol_ref);
    assign p103      = scl_p97_reg + scl_p6_reg;
    assign in_window = (p103 > ref_ext) && (scl_p97_reg <= ref_ext);

    // fraction priority: half, quarter, eighth
    always_comb begin
        if (scl_div_reg[3]) begin
            frac = fbd_pkg::FRAC_HALF;
        end else if (scl_div_reg[2]) begin
            frac = fbd_pkg::FRAC_QUARTER;
        end else if (scl_div_reg[1]) begin
            frac = fbd_pkg::FRAC_EIGHTH;
        end else begin
            frac = fbd_pkg::FRAC_NONE;
        end
    end

    // final result by request kind
    always_comb begin
        case (scl_kind_reg)
            fbd_pkg::KIND_ZERO: begin
                ok_next   = 1'b0;
                code_next = '0;
            end
            fbd_pkg::KIND_NEAR3M: begin
                ok_next   = 1'b1;
                code_next = fbd_pkg::CODE_3M;
            end
            fbd_pkg::KIND_NEAR2M: begin
                ok_next   = 1'b1;
                code_next = fbd_pkg::CODE_2M;
            end
            default: begin
                ok_next   = in_window;
                code_next = in_window ? {frac, scl_div_reg[LW-1:4]} : '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en_out && scl_vld_reg) begin
            ok_reg   <= ok_next;
            code_reg <= code_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign out_rate_ok = ok_reg;
    assign out_code    = code_reg;

    // rejected beats carry a zero code
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !ok_reg |-> code_reg == '0)
        else $error("rejected result with nonzero code");

    // a stalled output stage holds the beat behind it
    a_scale_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !out_ready && scl_vld_reg |=> scl_vld_reg && $stable(scl_p97_reg))
        else $error("scale stage lost a beat under stall");

    // an empty output stage always takes the waiting beat
    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg && scl_vld_reg |=> out_vld_reg)
        else $error("output stage failed to take a beat");

endmodule

>>> rtl/fractional_baud_divisor_top.sv
// top level: config registers, request classify stage and pipeline hookup
// throughput: one request per cycle while m_ready does not back-pressure the output,
//   set by the 14-stage divider pipeline that retires two quotient bits per stage
// reset: synchronous active-low aresetn clears all pipeline valids and
//   loads base clock 3000000, divisor min 32 and divisor max 262136
module fractional_baud_divisor_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [fbd_pkg::BASE_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fbd_pkg::BAUD_W-1:0]          s_baud_rate,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_rate_ok,
    output logic [fbd_pkg::CODE_W-1:0]          m_divisor_code
);

    localparam int RW = fbd_pkg::RATE_BITS;
    localparam int AW = fbd_pkg::ATH_W;

    logic [fbd_pkg::BASE_W-1:0] base_clock_reg;
    logic [fbd_pkg::LIM_W-1:0]  div_min_reg;
    logic [fbd_pkg::LIM_W-1:0]  div_max_reg;
    logic [AW-1:0]              tol_ref_reg;

    logic                       in_vld_reg;
    fbd_pkg::fbd_side_t         in_side_reg;
    logic [fbd_pkg::DIV_W-1:0]  in_dvd_reg;

    logic [RW-1:0]              rate;
    logic [1:0]                 kind_next;
    logic [AW-1:0]              ref16;

    logic                       div_ready;
    logic                       div_valid;
    fbd_pkg::fbd_side_t         div_side;
    logic [fbd_pkg::DIV_W-1:0]  div_quot;

    logic                       rnd_ready;
    logic                       rnd_valid;
    fbd_pkg::fbd_side_t         rnd_side;
    logic [fbd_pkg::LIM_W-1:0]  rnd_div;

    logic                       tol_ready;
    logic                       in_en;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_clock_reg <= fbd_pkg::BASE_CLOCK_RST;
            div_min_reg    <= fbd_pkg::DIV_MIN_RST;
            div_max_reg    <= fbd_pkg::DIV_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                fbd_pkg::REG_BASE_CLOCK: base_clock_reg <= cfg_wdata;
                fbd_pkg::REG_DIV_MIN:    div_min_reg    <= cfg_wdata[fbd_pkg::LIM_W-1:0];
                fbd_pkg::REG_DIV_MAX:    div_max_reg    <= cfg_wdata[fbd_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // tolerance reference: sixteen times base clock, times 100
    assign ref16 = AW'(base_clock_reg) << 4;

    always_ff @(posedge aclk) begin
        tol_ref_reg <= (ref16 << 6) + (ref16 << 5) + (ref16 << 2);
    end

    // classify the request rate
    assign rate = s_baud_rate[RW-1:0];

    always_comb begin
        if (rate == '0) begin
            kind_next = fbd_pkg::KIND_ZERO;
        end else if (rate >= fbd_pkg::NEAR3M_LO && rate <= fbd_pkg::NEAR3M_HI) begin
            kind_next = fbd_pkg::KIND_NEAR3M;
        end else if (rate >= fbd_pkg::NEAR2M_LO && rate <= fbd_pkg::NEAR2M_HI) begin
            kind_next = fbd_pkg::KIND_NEAR2M;
        end else begin
            kind_next = fbd_pkg::KIND_CALC;
        end
    end

    // input stage
    assign in_en   = ~in_vld_reg | div_ready;
    assign s_ready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            in_side_reg.kind <= kind_next;
            in_side_reg.rate <= rate;
            in_dvd_reg       <= {base_clock_reg, 4'b0000};
        end
    end

    fbd_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_vld_reg),
        .in_ready    (div_ready),
        .in_side     (in_side_reg),
        .in_dividend (in_dvd_reg),
        .out_valid   (div_valid),
        .out_ready   (rnd_ready),
        .out_side    (div_side),
        .out_quot    (div_quot)
    );

    fbd_rnd u_rnd (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (div_valid),
        .in_ready    (rnd_ready),
        .in_side     (div_side),
        .in_quot     (div_quot),
        .divisor_min (div_min_reg),
        .divisor_max (div_max_reg),
        .out_valid   (rnd_valid),
        .out_ready   (tol_ready),
        .out_side    (rnd_side),
        .out_div     (rnd_div)
    );

    fbd_tol u_tol (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (rnd_valid),
        .in_ready    (tol_ready),
        .in_side     (rnd_side),
        .in_div      (rnd_div),
        .tol_ref     (tol_ref_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_rate_ok (m_rate_ok),
        .out_code    (m_divisor_code)
    );

endmodule

>>> test/tb_fractional_baud_divisor_top.sv
// self-checking testbench for the fractional baud divisor top level
module tb_fractional_baud_divisor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int DIRECTED_ROWS   = 22;

    // one result beat: ok flag and packed divisor
    typedef struct packed {
        logic                       ok;
        logic [fbd_pkg::CODE_W-1:0] code;
    } divisor_result_t;

    // directed row: rate, and a typed result where fixed is set
    typedef struct packed {
        logic [fbd_pkg::BAUD_W-1:0] rate;
        logic                       fixed;
        logic                       ok;
        logic [fbd_pkg::CODE_W-1:0] code;
    } baud_vector_t;

    // power-of-two rounding of the low divisor nibble
    localparam logic [4:0] NIBBLE_ROUND [16] = '{
        5'd0, 5'd2, 5'd2, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8,
        5'd8, 5'd8, 5'd8, 5'd8, 5'd16, 5'd16, 5'd16, 5'd16
    };

    // directed stimulus, typed results only where obvious
    localparam baud_vector_t DIRECTED_VECTORS [DIRECTED_ROWS] = '{
        '{24'd0,        1'b1, 1'b0, 16'h0000},            // zero rate
        '{24'd3000000,  1'b1, 1'b1, fbd_pkg::CODE_3M},
        '{24'd2912621,  1'b1, 1'b1, fbd_pkg::CODE_3M},    // 3M window low edge
        '{24'd3092783,  1'b1, 1'b1, fbd_pkg::CODE_3M},    // 3M window high edge
        '{24'd2912620,  1'b0, 1'b0, 16'h0000},
        '{24'd3092784,  1'b0, 1'b0, 16'h0000},
        '{24'd2000000,  1'b1, 1'b1, fbd_pkg::CODE_2M},
        '{24'd1941747,  1'b1, 1'b1, fbd_pkg::CODE_2M},    // 2M window low edge
        '{24'd2061855,  1'b1, 1'b1, fbd_pkg::CODE_2M},    // 2M window high edge
        '{24'd1941746,  1'b0, 1'b0, 16'h0000},
        '{24'd2061856,  1'b0, 1'b0, 16'h0000},
        '{24'd16777215, 1'b1, 1'b0, 16'h0000},   // max rate, clamped to floor
        '{24'd1,        1'b1, 1'b0, 16'h0000},   // min rate, clamped to ceiling
        '{24'd9600,     1'b1, 1'b1, 16'h4138},   // exact divisor 5000
        '{24'd115200,   1'b0, 1'b0, 16'h0000},
        '{24'd1021276,  1'b0, 1'b0, 16'h0000},   // rounding carries into integer
        '{24'd1454545,  1'b0, 1'b0, 16'h0000},   // eighth fraction
        '{24'd1333333,  1'b0, 1'b0, 16'h0000},   // quarter fraction
        '{24'd1500000,  1'b0, 1'b0, 16'h0000},   // divisor right at the floor
        '{24'd300,      1'b0, 1'b0, 16'h0000},
        '{24'd183,      1'b0, 1'b0, 16'h0000},   // just over the ceiling
        '{24'd12345678, 1'b0, 1'b0, 16'h0000}
    };

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [fbd_pkg::CFG_IDX_W-1:0]   cfg_addr;
    logic [fbd_pkg::BASE_W-1:0]      cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [fbd_pkg::BAUD_W-1:0]      s_baud_rate;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_rate_ok;
    logic [fbd_pkg::CODE_W-1:0]      m_divisor_code;

    // typed result carried alongside the request beat
    logic                            req_fixed;
    logic                            req_fixed_ok;
    logic [fbd_pkg::CODE_W-1:0]      req_fixed_code;

    // shadow copy of the config registers
    logic [fbd_pkg::BASE_W-1:0]      cfg_base_clock;
    logic [fbd_pkg::LIM_W-1:0]       cfg_div_min;
    logic [fbd_pkg::LIM_W-1:0]       cfg_div_max;

    bit                              src_idle_en;
    bit                              sink_idle_en;
    int unsigned                     mismatch_count;
    divisor_result_t                 pending_divisors [$];

    fractional_baud_divisor_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_baud_rate    (s_baud_rate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rate_ok      (m_rate_ok),
        .m_divisor_code (m_divisor_code)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #300us;
        $display("DONE: errors detected");
        $finish;
    end

    // expected divisor code for one rate under the current registers
    function automatic divisor_result_t predict_divisor(
        input logic [fbd_pkg::BAUD_W-1:0] rate);
        divisor_result_t res;
        logic [63:0]     ref16;
        logic [63:0]     div;
        logic [63:0]     prod;
        logic [63:0]     tol_lo;
        logic [63:0]     tol_hi;
        res = '0;
        if (rate == '0) begin
            return res;
        end
        if (rate >= fbd_pkg::NEAR3M_LO && rate <= fbd_pkg::NEAR3M_HI) begin
            res.ok   = 1'b1;
            res.code = fbd_pkg::CODE_3M;
            return res;
        end
        if (rate >= fbd_pkg::NEAR2M_LO && rate <= fbd_pkg::NEAR2M_HI) begin
            res.ok   = 1'b1;
            res.code = fbd_pkg::CODE_2M;
            return res;
        end
        // raw divisor, nibble rounding, then clamp with the floor first
        ref16 = 64'(cfg_base_clock) << 4;
        div   = ref16 / 64'(rate);
        div   = (div & ~64'd15) + 64'(NIBBLE_ROUND[div[3:0]]);
        if (div < 64'(cfg_div_min)) begin
            div = 64'(cfg_div_min);
        end else if (div > 64'(cfg_div_max)) begin
            div = 64'(cfg_div_max);
        end
        // full-width tolerance window
        prod   = 64'(rate) * div;
        tol_lo = (ref16 * 64'd100) / 64'd103;
        tol_hi = (ref16 * 64'd100) / 64'd97;
        if (prod < tol_lo || prod > tol_hi) begin
            return res;
        end
        res.ok = 1'b1;
        res.code[fbd_pkg::INT_W-1:0] = div[fbd_pkg::INT_W+3:4];
        if (div[3]) begin
            res.code[fbd_pkg::CODE_W-1:fbd_pkg::INT_W] = fbd_pkg::FRAC_HALF;
        end else if (div[2]) begin
            res.code[fbd_pkg::CODE_W-1:fbd_pkg::INT_W] = fbd_pkg::FRAC_QUARTER;
        end else if (div[1]) begin
            res.code[fbd_pkg::CODE_W-1:fbd_pkg::INT_W] = fbd_pkg::FRAC_EIGHTH;
        end else begin
            res.code[fbd_pkg::CODE_W-1:fbd_pkg::INT_W] = fbd_pkg::FRAC_NONE;
        end
        return res;
    endfunction

    // random rate, weighted toward rates that land on a divisor
    function automatic logic [fbd_pkg::BAUD_W-1:0] draw_baud_rate();
        int unsigned                sel;
        int unsigned                sh;
        int unsigned                k;
        logic [63:0]                ref16;
        logic [fbd_pkg::BAUD_W-1:0] rate;
        sel   = $urandom_range(0, 99);
        ref16 = 64'(cfg_base_clock) << 4;
        rate  = '0;
        if (sel < 45) begin
            k = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4096) :
                                              $urandom_range(1, 262143);
            rate = fbd_pkg::BAUD_W'(ref16 / 64'(k));
        end else if (sel < 82 && sel >= 70) begin
            case ($urandom_range(0, 3))
                0:       rate = fbd_pkg::NEAR3M_LO;
                1:       rate = fbd_pkg::NEAR3M_HI;
                2:       rate = fbd_pkg::NEAR2M_LO;
                default: rate = fbd_pkg::NEAR2M_HI;
            endcase
            rate = rate + fbd_pkg::BAUD_W'($urandom_range(0, 6)) - fbd_pkg::BAUD_W'(3);
            return rate;
        end else if (sel >= 82 && sel < 95) begin
            return fbd_pkg::BAUD_W'($urandom);
        end else if (sel >= 95) begin
            return fbd_pkg::BAUD_W'($urandom_range(0, 3));
        end
        // log-uniform spread, also the fallback when the divisor pick gave zero
        if (rate == '0) begin
            sh   = $urandom_range(0, fbd_pkg::BAUD_W - 1);
            rate = fbd_pkg::BAUD_W'($urandom_range(1 << sh, (2 << sh) - 1));
        end
        return rate;
    endfunction

    // single register write, shadow copy follows
    task automatic write_reg(input logic [fbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbd_pkg::BASE_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            fbd_pkg::REG_BASE_CLOCK: cfg_base_clock = value;
            fbd_pkg::REG_DIV_MIN:    cfg_div_min    = value[fbd_pkg::LIM_W-1:0];
            fbd_pkg::REG_DIV_MAX:    cfg_div_max    = value[fbd_pkg::LIM_W-1:0];
            default:                 ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // write all three registers, junk above the 18-bit limits
    task automatic load_config(input logic [fbd_pkg::BASE_W-1:0] base,
                               input logic [fbd_pkg::LIM_W-1:0] dmin,
                               input logic [fbd_pkg::LIM_W-1:0] dmax);
        write_reg(fbd_pkg::REG_BASE_CLOCK, base);
        write_reg(fbd_pkg::REG_DIV_MIN, {6'($urandom), dmin});
        write_reg(fbd_pkg::REG_DIV_MAX, {6'($urandom), dmax});
    endtask

    // present one request beat and hold it until accepted
    task automatic send_rate(input logic [fbd_pkg::BAUD_W-1:0] rate, input logic fixed,
                             input logic ok, input logic [fbd_pkg::CODE_W-1:0] code);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_baud_rate    <= rate;
        req_fixed      <= fixed;
        req_fixed_ok   <= ok;
        req_fixed_code <= code;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_divisors.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // result sink with random stall bursts
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // beat tracking: queue predictions on requests, check on results
    always @(posedge aclk) begin
        divisor_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (req_fixed) begin
                    pending_divisors.push_back({req_fixed_ok, req_fixed_code});
                end else begin
                    pending_divisors.push_back(predict_divisor(s_baud_rate));
                end
            end
            if (m_valid && m_ready) begin
                if (pending_divisors.size() == 0) begin
                    $error("unexpected result beat: rate_ok=%0d divisor_code=%h",
                           m_rate_ok, m_divisor_code);
                    mismatch_count++;
                end else begin
                    want = pending_divisors.pop_front();
                    if (m_rate_ok !== want.ok) begin
                        $error("rate_ok: expected %0d, actual %0d", want.ok, m_rate_ok);
                        mismatch_count++;
                    end
                    if (m_divisor_code !== want.code) begin
                        $error("divisor_code: expected %h, actual %h",
                               want.code, m_divisor_code);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        logic [fbd_pkg::BASE_W-1:0] base_v;
        logic [fbd_pkg::LIM_W-1:0]  min_v;
        logic [fbd_pkg::LIM_W-1:0]  max_v;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = fbd_pkg::REG_BASE_CLOCK;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_baud_rate    = '0;
        req_fixed      = 1'b0;
        req_fixed_ok   = 1'b0;
        req_fixed_code = '0;
        cfg_base_clock = fbd_pkg::BASE_CLOCK_RST;
        cfg_div_min    = fbd_pkg::DIV_MIN_RST;
        cfg_div_max    = fbd_pkg::DIV_MAX_RST;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        mismatch_count = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows under reset values
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_rate(DIRECTED_VECTORS[i].rate, DIRECTED_VECTORS[i].fixed,
                      DIRECTED_VECTORS[i].ok, DIRECTED_VECTORS[i].code);
        end
        drain_results();

        // random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    // widest range of everything
                    base_v = 24'hFFFFFF; min_v = 18'd1; max_v = 18'h3FFFF;
                    src_idle_en = 1'b1; sink_idle_en = 1'b1;
                end
                1: begin
                    // floor above ceiling
                    base_v = 24'd1; min_v = 18'h3FFFF; max_v = 18'd1;
                    src_idle_en = 1'b1; sink_idle_en = 1'b0;
                end
                2: begin
                    // zero base clock and zero floor
                    base_v = '0; min_v = '0;
                    max_v  = fbd_pkg::LIM_W'($urandom_range(1, 262143));
                    src_idle_en = 1'b0; sink_idle_en = 1'b1;
                end
                3: begin
                    // odd clamp limits
                    base_v = fbd_pkg::BASE_W'($urandom_range(1, 16777215));
                    min_v  = fbd_pkg::LIM_W'($urandom_range(0, 31) * 2 + 1);
                    max_v  = fbd_pkg::LIM_W'($urandom_range(50000, 131070) * 2 + 1);
                    src_idle_en = 1'b1; sink_idle_en = 1'b1;
                end
                4: begin
                    // common uart reference clocks, no idling
                    case ($urandom_range(0, 3))
                        0:       base_v = 24'd1843200;
                        1:       base_v = 24'd6000000;
                        2:       base_v = 24'd12000000;
                        default: base_v = 24'd16777215;
                    endcase
                    min_v = fbd_pkg::DIV_MIN_RST; max_v = fbd_pkg::DIV_MAX_RST;
                    src_idle_en = 1'b0; sink_idle_en = 1'b0;
                end
                5: begin
                    base_v = fbd_pkg::BASE_W'($urandom_range(1, 16777215));
                    min_v  = fbd_pkg::LIM_W'($urandom_range(1, 262143));
                    max_v  = fbd_pkg::LIM_W'($urandom_range(1, 262143));
                    src_idle_en = 1'b1; sink_idle_en = 1'b1;
                end
                6: begin
                    // narrow clamp window
                    base_v = fbd_pkg::BASE_W'($urandom_range(1, 16777215));
                    min_v  = fbd_pkg::LIM_W'($urandom_range(1, 200000));
                    max_v  = min_v + fbd_pkg::LIM_W'($urandom_range(0, 16));
                    src_idle_en = 1'b1; sink_idle_en = 1'b1;
                end
                default: begin
                    // back to reset values, no idling to the end
                    base_v = fbd_pkg::BASE_CLOCK_RST;
                    min_v  = fbd_pkg::DIV_MIN_RST;
                    max_v  = fbd_pkg::DIV_MAX_RST;
                    src_idle_en = 1'b0; sink_idle_en = 1'b0;
                end
            endcase
            load_config(base_v, min_v, max_v);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_rate(draw_baud_rate(), 1'b0, 1'b0, '0);
            end
            drain_results();
        end

        // let the pipeline settle past its latency
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/fbd_pkg.sv
rtl/fbd_div.sv
rtl/fbd_rnd.sv
rtl/fbd_tol.sv
rtl/fractional_baud_divisor_top.sv
test/tb_fractional_baud_divisor_top.sv
